/* hdl/altf_pkg.sv */
package altf_pkg;

    // Fixed-point formats: Q2.16 signed values, Q0.16 registers
    localparam int QW      = 18;
    localparam int CW      = 16;
    localparam int MW      = 19;            // multiplier operand width
    localparam int PW      = 2 * MW;        // product width
    localparam int DIV_NW  = PW;            // divider dividend width
    localparam int DIV_DW  = MW;            // divider divisor width
    localparam int SQ_RW   = 40;            // square root radicand width
    localparam int SQ_QW   = SQ_RW / 2;     // square root result width

    localparam logic signed [QW-1:0] Q_MAX = 18'sd131071;
    localparam logic signed [QW-1:0] Q_MIN = -18'sd131072;
    localparam logic signed [QW-1:0] ONE_Q = 18'sd65536;
    localparam logic signed [QW-1:0] NEG_ONE_Q = -18'sd65536;
    localparam logic [PW-1:0] ACC_CAP = PW'(262143);

    // Register map (word index)
    localparam logic [1:0] REG_MAX_SPEED  = 2'd0;
    localparam logic [1:0] REG_ACCEL_TIME = 2'd1;
    localparam logic [1:0] REG_DEAD_ZONE  = 2'd2;

    localparam logic [CW-1:0] MAX_SPEED_RST  = 16'd15888;
    localparam logic [CW-1:0] ACCEL_TIME_RST = 16'd9830;
    localparam logic [CW-1:0] DEAD_ZONE_RST  = 16'd655;

    typedef enum logic [5:0] {
        ST_IDLE, ST_CHK, ST_DT, ST_ADIV, ST_ADIV_W,
        ST_DX2, ST_DY2, ST_DSQ, ST_DSQ_W,
        ST_NX, ST_NXD, ST_NXD_W, ST_NY, ST_NYD, ST_NYD_W,
        ST_AX2, ST_AY2, ST_ASQ, ST_ASQ_W,
        ST_LX, ST_LXD, ST_LXD_W, ST_LY, ST_LYD, ST_LYD_W,
        ST_SPD, ST_A2, ST_AD, ST_SSQ, ST_SSQ_W,
        ST_SX2, ST_SY2, ST_VSQ, ST_VSQ_W,
        ST_CX, ST_CXD, ST_CXD_W, ST_CY, ST_CYD, ST_CYD_W,
        ST_POS, ST_OUT
    } altf_state_t;

    // Magnitude of a 19-bit signed value
    function automatic logic [MW-1:0] abs19(input logic signed [MW-1:0] v);
        logic [MW-1:0] r;
        r = v[MW-1] ? MW'(-v) : MW'(v);
        return r;
    endfunction

    // Saturate a 20-bit sum to Q2.16
    function automatic logic signed [QW-1:0] sat18(input logic signed [QW+1:0] v);
        logic signed [QW-1:0] r;
        if (v > QW'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < $signed({{2{Q_MIN[QW-1]}}, Q_MIN})) begin
            r = Q_MIN;
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/altf_div.sv */
module altf_div
    import altf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [DIV_NW-1:0] quot
);

    localparam int CNTW = $clog2(DIV_NW);

    logic              busy_reg;
    logic              done_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW:0]   rem_sh;
    logic              fit;

    // One quotient bit per cycle, restoring
    assign rem_sh = {rem_reg, num_reg[DIV_NW-1]};
    assign fit    = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift dividend out and quotient in
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_NW-2:0], fit};
            rem_reg <= fit ? DIV_DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

/* hdl/altf_sqrt.sv */
module altf_sqrt
    import altf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SQ_RW-1:0] rad,
    output logic             done,
    output logic [SQ_QW-1:0] root
);

    localparam int CNTW = $clog2(SQ_QW);
    localparam int RW   = SQ_QW + 2;

    logic             busy_reg;
    logic             done_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic [SQ_RW-1:0] rad_reg;
    logic [RW-1:0]    rem_reg;
    logic [SQ_QW-1:0] root_reg;
    logic [RW+1:0]    rem_sh;
    logic [RW+1:0]    trial;
    logic             fit;

    // Two radicand bits per cycle, one root bit
    assign rem_sh = {rem_reg, rad_reg[SQ_RW-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fit    = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(SQ_QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[SQ_RW-3:0], 2'b00};
            rem_reg  <= fit ? RW'(rem_sh - trial) : rem_sh[RW-1:0];
            root_reg <= {root_reg[SQ_QW-2:0], fit};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* hdl/accel_limited_target_follower.sv */
// Acceleration-limited 2D target follower.
// Input channel (s_valid/s_ready): one tick carrying the target (Q2.16, clamped
// to +/-1) and the elapsed time (Q0.16). Result channel (m_valid/m_ready): one
// position per tick, each axis shown as zero when below the dead zone.
// Configuration over APB: max_speed at 0x0, accel_time at 0x4, dead_zone at 0x8.
// The first tick after reset and a settled tick skip the update. A full update
// runs three to seven passes of the shared divider (38 steps): two more each
// when the acceleration limit or the speed cap applies. It also runs four
// passes of the shared square root (20 steps), plus the multiply and update
// steps. One tick is processed at a time; s_ready is high only while the
// sequencer waits for a tick, so a new tick waits until the last is through.
// The result sits in an output register; a new tick is accepted while it waits.
// If the receiver stalls, the sequencer holds the next result until the output
// register frees up. Reset clears position, velocity and the started flag, and
// restores the register defaults.
module accel_limited_target_follower
    import altf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [QW-1:0] s_target_x,
    input  logic signed [QW-1:0] s_target_y,
    input  logic [CW-1:0]        s_delta_time,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [QW-1:0] m_pos_x,
    output logic signed [QW-1:0] m_pos_y,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    altf_state_t state_reg, state_next;

    logic [CW-1:0] max_speed_reg, accel_time_reg, dead_zone_reg;
    logic          started_reg;
    logic signed [QW-1:0] posx_reg, posy_reg, spx_reg, spy_reg;
    logic signed [MW-1:0] dx_reg, dy_reg, ax_reg, ay_reg;
    logic [CW-1:0]        dt_reg;
    logic [QW-1:0]        amax_reg;
    logic [MW-1:0]        dist_reg, len_reg, stop_reg;
    logic [PW-1:0]        sum_reg, prod_reg;
    logic                 m_valid_reg;
    logic signed [QW-1:0] m_pos_x_reg, m_pos_y_reg;

    logic [MW-1:0]     mul_a, mul_b;
    logic              div_start, div_done, sq_start, sq_done;
    logic [DIV_NW-1:0] div_num, div_quot;
    logic [DIV_DW-1:0] div_den;
    logic [SQ_RW-1:0]  sq_rad;
    logic [SQ_QW-1:0]  sq_root;
    logic              out_free;
    logic signed [QW-1:0] tx_c, ty_c;
    logic [MW-1:0]     q19;

    assign out_free = !m_valid_reg || m_ready;
    assign q19      = div_quot[MW-1:0];

    // Clamp the target to +/-1
    always_comb begin
        tx_c = s_target_x;
        if (s_target_x > ONE_Q) tx_c = ONE_Q;
        if (s_target_x < NEG_ONE_Q) tx_c = NEG_ONE_Q;
        ty_c = s_target_y;
        if (s_target_y > ONE_Q) ty_c = ONE_Q;
        if (s_target_y < NEG_ONE_Q) ty_c = NEG_ONE_Q;
    end

    // APB register file
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg  <= MAX_SPEED_RST;
            accel_time_reg <= ACCEL_TIME_RST;
            dead_zone_reg  <= DEAD_ZONE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_MAX_SPEED:  max_speed_reg  <= pwdata[CW-1:0];
                REG_ACCEL_TIME: accel_time_reg <= pwdata[CW-1:0];
                REG_DEAD_ZONE:  dead_zone_reg  <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_SPEED:  prdata = {16'd0, max_speed_reg};
            REG_ACCEL_TIME: prdata = {16'd0, accel_time_reg};
            REG_DEAD_ZONE:  prdata = {16'd0, dead_zone_reg};
            default:        prdata = '0;
        endcase
    end

    // Shared units
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    altf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    altf_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .rad     (sq_rad),
        .done    (sq_done),
        .root    (sq_root)
    );

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state and unit operands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = prod_reg;
        div_den    = '0;
        sq_start   = 1'b0;
        sq_rad     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = started_reg ? ST_CHK : ST_OUT;
                end
            end
            ST_CHK: begin
                if (abs19(dx_reg) <= MW'(dead_zone_reg) &&
                    abs19(dy_reg) <= MW'(dead_zone_reg)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DT;
                end
            end
            ST_DT: begin
                mul_a = MW'(dt_reg);
                mul_b = MW'(max_speed_reg);
                state_next = ST_ADIV;
            end
            ST_ADIV: begin
                div_start = 1'b1;
                div_den = (accel_time_reg == '0) ? DIV_DW'(1) : DIV_DW'(accel_time_reg);
                state_next = ST_ADIV_W;
            end
            ST_ADIV_W: if (div_done) state_next = ST_DX2;
            ST_DX2: begin
                mul_a = abs19(dx_reg);
                mul_b = abs19(dx_reg);
                state_next = ST_DY2;
            end
            ST_DY2: begin
                mul_a = abs19(dy_reg);
                mul_b = abs19(dy_reg);
                state_next = ST_DSQ;
            end
            ST_DSQ: begin
                sq_start = 1'b1;
                sq_rad = SQ_RW'(sum_reg) + SQ_RW'(prod_reg);
                state_next = ST_DSQ_W;
            end
            ST_DSQ_W: if (sq_done) state_next = ST_NX;
            ST_NX: begin
                mul_a = MW'(max_speed_reg);
                mul_b = abs19(dx_reg);
                state_next = ST_NXD;
            end
            ST_NXD: begin
                div_start = 1'b1;
                div_den = dist_reg;
                state_next = ST_NXD_W;
            end
            ST_NXD_W: if (div_done) state_next = ST_NY;
            ST_NY: begin
                mul_a = MW'(max_speed_reg);
                mul_b = abs19(dy_reg);
                state_next = ST_NYD;
            end
            ST_NYD: begin
                div_start = 1'b1;
                div_den = dist_reg;
                state_next = ST_NYD_W;
            end
            ST_NYD_W: if (div_done) state_next = ST_AX2;
            ST_AX2: begin
                mul_a = abs19(ax_reg);
                mul_b = abs19(ax_reg);
                state_next = ST_AY2;
            end
            ST_AY2: begin
                mul_a = abs19(ay_reg);
                mul_b = abs19(ay_reg);
                state_next = ST_ASQ;
            end
            ST_ASQ: begin
                sq_start = 1'b1;
                sq_rad = SQ_RW'(sum_reg) + SQ_RW'(prod_reg);
                state_next = ST_ASQ_W;
            end
            ST_ASQ_W: begin
                if (sq_done) begin
                    state_next = (sq_root > SQ_QW'(amax_reg)) ? ST_LX : ST_SPD;
                end
            end
            ST_LX: begin
                mul_a = abs19(ax_reg);
                mul_b = MW'(amax_reg);
                state_next = ST_LXD;
            end
            ST_LXD: begin
                div_start = 1'b1;
                div_den = len_reg;
                state_next = ST_LXD_W;
            end
            ST_LXD_W: if (div_done) state_next = ST_LY;
            ST_LY: begin
                mul_a = abs19(ay_reg);
                mul_b = MW'(amax_reg);
                state_next = ST_LYD;
            end
            ST_LYD: begin
                div_start = 1'b1;
                div_den = len_reg;
                state_next = ST_LYD_W;
            end
            ST_LYD_W: if (div_done) state_next = ST_SPD;
            ST_SPD: state_next = ST_A2;
            ST_A2: begin
                mul_a = MW'(amax_reg);
                mul_b = MW'(amax_reg);
                state_next = ST_AD;
            end
            ST_AD: begin
                mul_a = MW'(amax_reg);
                mul_b = dist_reg;
                state_next = ST_SSQ;
            end
            ST_SSQ: begin
                sq_start = 1'b1;
                sq_rad = SQ_RW'(sum_reg) + {prod_reg[SQ_RW-4:0], 3'b000};
                state_next = ST_SSQ_W;
            end
            ST_SSQ_W: if (sq_done) state_next = ST_SX2;
            ST_SX2: begin
                mul_a = abs19(MW'(spx_reg));
                mul_b = abs19(MW'(spx_reg));
                state_next = ST_SY2;
            end
            ST_SY2: begin
                mul_a = abs19(MW'(spy_reg));
                mul_b = abs19(MW'(spy_reg));
                state_next = ST_VSQ;
            end
            ST_VSQ: begin
                sq_start = 1'b1;
                sq_rad = SQ_RW'(sum_reg) + SQ_RW'(prod_reg);
                state_next = ST_VSQ_W;
            end
            ST_VSQ_W: begin
                if (sq_done) begin
                    state_next = (sq_root > SQ_QW'(stop_reg)) ? ST_CX : ST_POS;
                end
            end
            ST_CX: begin
                mul_a = abs19(MW'(spx_reg));
                mul_b = stop_reg;
                state_next = ST_CXD;
            end
            ST_CXD: begin
                div_start = 1'b1;
                div_den = len_reg;
                state_next = ST_CXD_W;
            end
            ST_CXD_W: if (div_done) state_next = ST_CY;
            ST_CY: begin
                mul_a = abs19(MW'(spy_reg));
                mul_b = stop_reg;
                state_next = ST_CYD;
            end
            ST_CYD: begin
                div_start = 1'b1;
                div_den = len_reg;
                state_next = ST_CYD_W;
            end
            ST_CYD_W: if (div_done) state_next = ST_POS;
            ST_POS: state_next = ST_OUT;
            ST_OUT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state: started flag, position, velocity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            posx_reg    <= '0;
            posy_reg    <= '0;
            spx_reg     <= '0;
            spy_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: if (s_valid) started_reg <= 1'b1;
                ST_SPD: begin
                    spx_reg <= sat18(20'(spx_reg) + 20'(ax_reg));
                    spy_reg <= sat18(20'(spy_reg) + 20'(ay_reg));
                end
                ST_CXD_W: begin
                    if (div_done) spx_reg <= spx_reg[QW-1] ? QW'(-q19) : QW'(q19);
                end
                ST_CYD_W: begin
                    if (div_done) spy_reg <= spy_reg[QW-1] ? QW'(-q19) : QW'(q19);
                end
                ST_POS: begin
                    posx_reg <= sat18(20'(posx_reg) + 20'(spx_reg));
                    posy_reg <= sat18(20'(posy_reg) + 20'(spy_reg));
                end
                default: ;
            endcase
        end
    end

    // Working registers of one tick
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                dx_reg <= MW'(tx_c) - MW'(posx_reg);
                dy_reg <= MW'(ty_c) - MW'(posy_reg);
                dt_reg <= s_delta_time;
            end
            ST_ADIV_W: begin
                if (div_done) begin
                    amax_reg <= (div_quot > ACC_CAP) ? QW'(ACC_CAP) : div_quot[QW-1:0];
                end
            end
            ST_DY2, ST_AY2, ST_AD, ST_SY2: sum_reg <= prod_reg;
            ST_DSQ_W: begin
                if (sq_done) dist_reg <= (sq_root == '0) ? MW'(1) : sq_root[MW-1:0];
            end
            ST_NXD_W: begin
                if (div_done) ax_reg <= (dx_reg[MW-1] ? -q19 : q19) - MW'(spx_reg);
            end
            ST_NYD_W: begin
                if (div_done) ay_reg <= (dy_reg[MW-1] ? -q19 : q19) - MW'(spy_reg);
            end
            ST_ASQ_W, ST_VSQ_W: if (sq_done) len_reg <= sq_root[MW-1:0];
            ST_LXD_W: if (div_done) ax_reg <= ax_reg[MW-1] ? -q19 : q19;
            ST_LYD_W: if (div_done) ay_reg <= ay_reg[MW-1] ? -q19 : q19;
            ST_SSQ_W: begin
                if (sq_done) stop_reg <= MW'((sq_root - SQ_QW'(amax_reg)) >> 1);
            end
            default: ;
        endcase
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_pos_x_reg <= (abs19(MW'(posx_reg)) < MW'(dead_zone_reg)) ? '0 : posx_reg;
            m_pos_y_reg <= (abs19(MW'(posy_reg)) < MW'(dead_zone_reg)) ? '0 : posy_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pos_x = m_pos_x_reg;
    assign m_pos_y = m_pos_y_reg;

    // First tick only raises the started flag and goes straight to output
    a_first_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && !started_reg) |=>
            (started_reg && state_reg == ST_OUT))
        else $error("first tick did not bypass the update");

    // Divisor for the direction divide is never zero
    a_dist_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NXD || state_reg == ST_NYD) |-> (dist_reg != '0))
        else $error("zero distance used as divisor");

    // Loading the output register always raises m_valid
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not presented");

    // Position update is always followed by output
    a_pos_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POS) |=> (state_reg == ST_OUT))
        else $error("position update not followed by output");

endmodule
